>>> hdl/alc_pkg.sv
// Shared types, codes and constants for the audio level chain.
package alc_pkg;

  // Field and register widths
  localparam int SAMPLE_W   = 16;
  localparam int VALUE_W    = 12;
  localparam int CLASS_W    = 2;
  localparam int WLEN_W     = 3;
  localparam int GAIN_W     = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  // Register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_TENTHS   = 2'd1;

  localparam logic [WLEN_W-1:0] WLEN_RESET = 3'd4;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 11'd10;

  // Clip limit and derived datapath widths
  localparam int CLIP_MAX = 15;
  localparam int SQ_MAX   = CLIP_MAX * CLIP_MAX;
  localparam int SM_W     = 5;                 // signed clipped / smoothed value
  localparam int SQV_W    = 8;                 // one square, at most SQ_MAX
  localparam int MEAN_W   = 8;                 // mean of squares, at most SQ_MAX
  localparam int ROOT_W   = 4;                 // floor sqrt of MEAN_W bits
  localparam int BIT_W    = 2;                 // root digit counter

  // Divide by tap count as multiply by ceil(2^16 / n); exact for n <= 16
  // and numerators up to 16 * SQ_MAX.
  localparam int RECIP_W     = 17;
  localparam int RECIP_SHIFT = 16;
  localparam int RECIP_N     = 17;
  localparam int RECIP_IDX_W = 5;
  localparam logic [RECIP_W-1:0] RECIP_TAB [RECIP_N] = '{
    17'd65536, 17'd65536, 17'd32768, 17'd21846, 17'd16384, 17'd13108,
    17'd10923, 17'd9363,  17'd8192,  17'd7282,  17'd6554,  17'd5958,
    17'd5462,  17'd5042,  17'd4682,  17'd4370,  17'd4096
  };

  // Divide by ten as multiply by 52429 >> 19; exact below 2^18
  localparam int              DIV10_W     = 16;
  localparam logic [DIV10_W-1:0] DIV10_MUL = 16'd52429;
  localparam int              DIV10_SHIFT = 19;

  localparam int LEVEL_HI = 30;
  localparam int LEVEL_LO = -30;

  typedef enum logic [CLASS_W-1:0] {
    LVL_OVER    = 2'd0,
    LVL_UNDER   = 2'd1,
    LVL_NOMINAL = 2'd2
  } level_class_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ACCUM,
    S_DIVSUM,
    S_SMOOTH,
    S_DIVMEAN,
    S_SQRT,
    S_GAIN,
    S_DIV10,
    S_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic start;
    logic acc_step;
    logic div_sum;
    logic smooth;
    logic div_mean;
    logic sqrt_step;
    logic gain;
    logic div10;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic single_tap;
    logic acc_last;
    logic sqrt_last;
  } dp_sts_t;

endpackage

>>> hdl/audio_level_chain.sv
// Top level of the audio level chain.
// Each accepted sample is clipped to +/-15 tenths, smoothed by an n-tap
// moving average, reduced to the floored square root of the mean of the
// last n smoothed squares, scaled by gain_tenths / 10 and classified as
// overload, underload or nominal. One result word per sample. Words are
// handled one at a time by a state machine over a shared datapath, with n
// being window_length clamped to 1..MAX_TAPS. From acceptance to its
// result register a word goes through n - 1 history accumulation steps,
// one reciprocal multiply for each of the two divides by n, the smoothing
// step, four square root digit steps, the gain and divide by ten
// multiplies, and the output load; the next sample is taken only after
// that load. A result held by out_stall delays the output load and with
// it the next sample. A finished result waits in the output register
// while the next sample is accepted. window_length and gain_tenths may
// only be written while idle.
module audio_level_chain #(
  parameter int MAX_TAPS = 4
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [alc_pkg::SAMPLE_W-1:0] in_sample,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [alc_pkg::VALUE_W-1:0]  out_level_value,
  output logic [alc_pkg::CLASS_W-1:0]         out_level_class,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [alc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [alc_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import alc_pkg::*;

  localparam int TAP_W = $clog2(MAX_TAPS + 1);

  logic [TAP_W-1:0]         taps;
  logic signed [GAIN_W-1:0] gain;
  dp_cmd_t                  cmd;
  dp_sts_t                  sts;

  alc_cfg #(
    .MAX_TAPS (MAX_TAPS)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .taps      (taps),
    .gain      (gain)
  );

  alc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  alc_dp #(
    .MAX_TAPS (MAX_TAPS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .sample      (in_sample),
    .taps        (taps),
    .gain        (gain),
    .level_value (out_level_value),
    .level_class (out_level_class)
  );

endmodule

>>> hdl/alc_cfg.sv
// Configuration registers and tap count clamp.
module alc_cfg #(
  parameter int MAX_TAPS = 4
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [alc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [alc_pkg::CFG_DATA_W-1:0]      cfg_data,
  output logic [$clog2(MAX_TAPS+1)-1:0]       taps,
  output logic signed [alc_pkg::GAIN_W-1:0]   gain
);
  import alc_pkg::*;

  localparam int TAP_W = $clog2(MAX_TAPS + 1);

  logic [WLEN_W-1:0] wlen_r;
  logic [GAIN_W-1:0] gain_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlen_r <= WLEN_RESET;
      gain_r <= GAIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_WINDOW_LENGTH: wlen_r <= cfg_data[WLEN_W-1:0];
        CFG_GAIN_TENTHS:   gain_r <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // zero taps behaves as one, above the build limit saturates
  always_comb begin
    if (wlen_r == '0) begin
      taps = TAP_W'(1);
    end else if (int'(wlen_r) > MAX_TAPS) begin
      taps = TAP_W'(MAX_TAPS);
    end else begin
      taps = TAP_W'(wlen_r);
    end
  end

  assign gain = $signed(gain_r);

endmodule

>>> hdl/alc_dp.sv
// Datapath: clip, windowed sums, reciprocal divides, digit square root, gain.
module alc_dp #(
  parameter int MAX_TAPS = 4
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  alc_pkg::dp_cmd_t                    cmd,
  output alc_pkg::dp_sts_t                    sts,
  input  logic signed [alc_pkg::SAMPLE_W-1:0] sample,
  input  logic [$clog2(MAX_TAPS+1)-1:0]       taps,
  input  logic signed [alc_pkg::GAIN_W-1:0]   gain,
  output logic signed [alc_pkg::VALUE_W-1:0]  level_value,
  output logic [alc_pkg::CLASS_W-1:0]         level_class
);
  import alc_pkg::*;

  localparam int HIST_D = (MAX_TAPS > 1) ? MAX_TAPS - 1 : 1;
  localparam int IDX_W  = (HIST_D > 1) ? $clog2(HIST_D) : 1;
  localparam int TAP_W  = $clog2(MAX_TAPS + 1);
  localparam int SUM_W  = $clog2(CLIP_MAX * MAX_TAPS + 1) + 1;
  localparam int SQ_W   = $clog2(SQ_MAX * MAX_TAPS + 1);
  localparam int PN_W   = SQ_W + RECIP_W;
  localparam int GP_W   = ROOT_W + 1 + GAIN_W;
  localparam int QM_W   = SM_W - 1;
  localparam int Q10_W  = VALUE_W - 1;
  localparam int RSQ_W  = 2 * ROOT_W + 1;

  logic signed [SM_W-1:0]    clip_hist_r   [HIST_D];
  logic signed [SM_W-1:0]    smooth_hist_r [HIST_D];
  logic signed [SM_W-1:0]    clip_r;
  logic signed [SUM_W-1:0]   sum_r;
  logic [SQ_W-1:0]           sq_r;
  logic [TAP_W-1:0]          k_r;
  logic [PN_W-1:0]           div_prod_r;
  logic                      div_neg_r;
  logic signed [SM_W-1:0]    sm_r;
  logic [ROOT_W-1:0]         root_r;
  logic [BIT_W-1:0]          bit_r;
  logic signed [GP_W-1:0]    gprod_r;
  logic signed [VALUE_W-1:0] val_r;
  logic signed [VALUE_W-1:0] value_r;
  logic [CLASS_W-1:0]        class_r;

  logic signed [SM_W-1:0]    clip_c;
  logic signed [SM_W-1:0]    clip_tap;
  logic signed [SM_W-1:0]    smooth_tap;
  logic signed [2*SM_W-1:0]  tap_sq_full;
  logic [SUM_W-1:0]          sum_abs;
  logic [SQ_W-1:0]           div_num;
  logic [RECIP_W-1:0]        recip;
  logic [PN_W-1:0]           div_mul;
  logic [QM_W-1:0]           qs;
  logic signed [SM_W-1:0]    sm;
  logic signed [2*SM_W-1:0]  sm_sq_full;
  logic [MEAN_W-1:0]         mean;
  logic [ROOT_W-1:0]         trial;
  logic [2*ROOT_W-1:0]       trial_sq;
  logic [GP_W-1:0]           gabs;
  logic [GP_W+DIV10_W-1:0]   q10_full;
  logic [Q10_W-1:0]          q10;
  logic signed [VALUE_W-1:0] val;
  level_class_t              cls;
  logic [RSQ_W-1:0]          root_lo_sq;
  logic [RSQ_W-1:0]          root_hi_sq;

  // clip to +/-15
  always_comb begin
    if (sample > $signed(SAMPLE_W'(CLIP_MAX))) begin
      clip_c = $signed(SM_W'(CLIP_MAX));
    end else if (sample < -$signed(SAMPLE_W'(CLIP_MAX))) begin
      clip_c = -$signed(SM_W'(CLIP_MAX));
    end else begin
      clip_c = sample[SM_W-1:0];
    end
  end

  assign clip_tap    = clip_hist_r[k_r[IDX_W-1:0]];
  assign smooth_tap  = smooth_hist_r[k_r[IDX_W-1:0]];
  assign tap_sq_full = (2*SM_W)'(smooth_tap) * (2*SM_W)'(smooth_tap);

  // shared reciprocal multiply for both divides by the tap count
  assign sum_abs = sum_r[SUM_W-1] ? $unsigned(-sum_r) : $unsigned(sum_r);
  assign div_num = cmd.div_sum ? SQ_W'(sum_abs) : sq_r;
  assign recip   = RECIP_TAB[RECIP_IDX_W'(taps)];
  assign div_mul = PN_W'(div_num) * PN_W'(recip);

  assign qs         = div_prod_r[RECIP_SHIFT +: QM_W];
  assign sm         = div_neg_r ? -$signed({1'b0, qs}) : $signed({1'b0, qs});
  assign sm_sq_full = (2*SM_W)'(sm) * (2*SM_W)'(sm);
  assign mean       = div_prod_r[RECIP_SHIFT +: MEAN_W];

  // one root digit per step
  assign trial    = root_r | (ROOT_W'(1) << bit_r);
  assign trial_sq = (2*ROOT_W)'(trial) * (2*ROOT_W)'(trial);

  assign gabs     = gprod_r[GP_W-1] ? $unsigned(-gprod_r) : $unsigned(gprod_r);
  assign q10_full = (GP_W+DIV10_W)'(gabs) * (GP_W+DIV10_W)'(DIV10_MUL);
  assign q10      = q10_full[DIV10_SHIFT +: Q10_W];
  assign val      = gprod_r[GP_W-1] ? -$signed({1'b0, q10}) : $signed({1'b0, q10});

  always_comb begin
    if (val_r > $signed(VALUE_W'(LEVEL_HI))) begin
      cls = LVL_OVER;
    end else if (val_r < $signed(VALUE_W'(LEVEL_LO))) begin
      cls = LVL_UNDER;
    end else begin
      cls = LVL_NOMINAL;
    end
  end

  assign sts.single_tap = (taps == TAP_W'(1));
  assign sts.acc_last   = (({1'b0, k_r} + (TAP_W+1)'(2)) == {1'b0, taps});
  assign sts.sqrt_last  = (bit_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < HIST_D; i++) begin
        clip_hist_r[i]   <= '0;
        smooth_hist_r[i] <= '0;
      end
    end else if (cmd.finish) begin
      for (int i = HIST_D - 1; i > 0; i--) begin
        clip_hist_r[i]   <= clip_hist_r[i-1];
        smooth_hist_r[i] <= smooth_hist_r[i-1];
      end
      clip_hist_r[0]   <= clip_r;
      smooth_hist_r[0] <= sm_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      clip_r <= clip_c;
      sum_r  <= SUM_W'(clip_c);
      sq_r   <= '0;
      k_r    <= '0;
    end
    if (cmd.acc_step) begin
      sum_r <= sum_r + SUM_W'(clip_tap);
      sq_r  <= sq_r + SQ_W'(tap_sq_full[SQV_W-1:0]);
      k_r   <= k_r + TAP_W'(1);
    end
    if (cmd.div_sum) begin
      div_prod_r <= div_mul;
      div_neg_r  <= sum_r[SUM_W-1];
    end
    if (cmd.smooth) begin
      sm_r <= sm;
      sq_r <= sq_r + SQ_W'(sm_sq_full[SQV_W-1:0]);
    end
    if (cmd.div_mean) begin
      div_prod_r <= div_mul;
      root_r     <= '0;
      bit_r      <= BIT_W'(ROOT_W - 1);
    end
    if (cmd.sqrt_step) begin
      if (trial_sq <= mean) begin
        root_r <= trial;
      end
      bit_r <= bit_r - BIT_W'(1);
    end
    if (cmd.gain) begin
      gprod_r <= GP_W'($signed({1'b0, root_r})) * GP_W'(gain);
    end
    if (cmd.div10) begin
      val_r <= val;
    end
    if (cmd.finish) begin
      value_r <= val_r;
      class_r <= cls;
    end
  end

  assign level_value = value_r;
  assign level_class = class_r;

  assign root_lo_sq = RSQ_W'(root_r) * RSQ_W'(root_r);
  assign root_hi_sq = (RSQ_W'(root_r) + RSQ_W'(1)) * (RSQ_W'(root_r) + RSQ_W'(1));

  // root is the floored square root of the mean when the gain step uses it
  a_root_floor: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.gain |-> (root_lo_sq <= RSQ_W'(mean)) && (root_hi_sq > RSQ_W'(mean)))
    else $error("square root out of bounds");

  // smoothed value stays within the clip range
  a_sm_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.smooth |=> (sm_r <= $signed(SM_W'(CLIP_MAX))) &&
                   (sm_r >= -$signed(SM_W'(CLIP_MAX))))
    else $error("smoothed value out of range");

endmodule

>>> hdl/alc_ctrl.sv
// Controller: sequences one word through the datapath and owns the handshakes.
module alc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  alc_pkg::dp_sts_t  sts,
  output alc_pkg::dp_cmd_t  cmd
);
  import alc_pkg::*;

  ctrl_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = sts.single_tap ? S_DIVSUM : S_ACCUM;
        end
      end
      S_ACCUM: begin
        cmd.acc_step = 1'b1;
        if (sts.acc_last) begin
          state_nxt = S_DIVSUM;
        end
      end
      S_DIVSUM: begin
        cmd.div_sum = 1'b1;
        state_nxt   = S_SMOOTH;
      end
      S_SMOOTH: begin
        cmd.smooth = 1'b1;
        state_nxt  = S_DIVMEAN;
      end
      S_DIVMEAN: begin
        cmd.div_mean = 1'b1;
        state_nxt    = S_SQRT;
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (sts.sqrt_last) begin
          state_nxt = S_GAIN;
        end
      end
      S_GAIN: begin
        cmd.gain  = 1'b1;
        state_nxt = S_DIV10;
      end
      S_DIV10: begin
        cmd.div10 = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // output register free, or its word leaves at this edge
        if (!out_valid_r || !out_stall) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second word taken while one is in flight");

  a_valid_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.finish))
    else $error("result shown without a finished word");

  a_finish_loads: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_valid_r)
    else $error("finished word not presented");

endmodule

>>> sim/testbench.sv
// Self-checking testbench for audio_level_chain: random samples and settings against a predictor.
module testbench;
  import alc_pkg::*;

  localparam int TAPS        = 4;
  localparam int HIST        = TAPS - 1;
  localparam int GAIN_DIV    = 10;
  localparam int MAX_WAIT    = 11;
  localparam int HOLD_CYCLES = 160;
  localparam int SETTLE      = TAPS + 16;
  localparam int WDOG_LIMIT  = 3000;
  localparam int BLOCKS      = 35;
  localparam int BLOCK_WORDS = 35;
  localparam int PRINT_CAP   = 40;

  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_B = 2'd3;

  localparam logic signed [SAMPLE_W-1:0] FULL_SCALE_WORDS [14] = '{
    32767, 32767, 32767, 32767, -32768, -32768, -32768, -32768,
    16, -16, 15, -15, 14, 0
  };

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    level_class_t              cls;
  } level_word_t;

  class level_scoreboard;
    logic [WLEN_W-1:0]        wlen;
    logic signed [GAIN_W-1:0] gain;
    int                       clip_taps [HIST];
    int                       smooth_taps [HIST];
    level_word_t              expected_levels [$];
    int                       errors;

    function new();
      wlen   = WLEN_RESET;
      gain   = GAIN_RESET;
      errors = 0;
      foreach (clip_taps[i]) begin
        clip_taps[i]   = 0;
        smooth_taps[i] = 0;
      end
    endfunction

    function void report(string msg);
      if (errors < PRINT_CAP) $display("MISMATCH: %s", msg);
      errors++;
    endfunction

    function void note_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_WINDOW_LENGTH) wlen = data[WLEN_W-1:0];
      else if (idx == CFG_GAIN_TENTHS) gain = data[GAIN_W-1:0];
    endfunction

    function void note_sample(logic signed [SAMPLE_W-1:0] word);
      int          taps, clip, sum, smooth, sq, mean, root, level;
      level_word_t w;
      taps = wlen;
      if (taps < 1) taps = 1;
      if (taps > TAPS) taps = TAPS;
      clip = word;
      if (clip > CLIP_MAX) clip = CLIP_MAX;
      else if (clip < -CLIP_MAX) clip = -CLIP_MAX;
      sum = clip;
      for (int j = 0; j < taps - 1; j++) sum += clip_taps[j];
      smooth = sum / taps;
      sq = smooth * smooth;
      for (int j = 0; j < taps - 1; j++) sq += smooth_taps[j] * smooth_taps[j];
      mean = sq / taps;
      root = 0;
      while ((root + 1) * (root + 1) <= mean) root++;
      level = (root * int'(gain)) / GAIN_DIV;
      w.value = level[VALUE_W-1:0];
      if (level > LEVEL_HI) w.cls = LVL_OVER;
      else if (level < LEVEL_LO) w.cls = LVL_UNDER;
      else w.cls = LVL_NOMINAL;
      for (int j = HIST - 1; j > 0; j--) begin
        clip_taps[j]   = clip_taps[j-1];
        smooth_taps[j] = smooth_taps[j-1];
      end
      clip_taps[0]   = clip;
      smooth_taps[0] = smooth;
      expected_levels.push_back(w);
    endfunction

    function void check_level(logic signed [VALUE_W-1:0] value, logic [CLASS_W-1:0] cls);
      level_word_t w;
      if (expected_levels.size() == 0) begin
        report($sformatf("unexpected word: value %0d class %0d", value, cls));
        return;
      end
      w = expected_levels.pop_front();
      if (value !== w.value)
        report($sformatf("level_value %0d, expected %0d", value, w.value));
      if (cls !== w.cls)
        report($sformatf("level_class %0d, expected %0d", cls, w.cls));
    endfunction
  endclass

  logic                        clk       = 1'b0;
  logic                        rst_n     = 1'b0;
  logic                        in_valid  = 1'b0;
  logic signed [SAMPLE_W-1:0]  in_sample = '0;
  logic                        out_stall = 1'b0;
  logic                        cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]        cfg_index = '0;
  logic [CFG_DATA_W-1:0]       cfg_data  = '0;
  logic                        in_stall;
  logic                        out_valid;
  logic signed [VALUE_W-1:0]   out_level_value;
  logic [CLASS_W-1:0]          out_level_class;
  logic                        cfg_ready;

  level_scoreboard sb = new();
  bit              calm = 1'b0;
  bit              hold_req = 1'b0;
  int              idle_cycles = 0;

  audio_level_chain #(.MAX_TAPS(TAPS)) DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_sample       (in_sample),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_level_value (out_level_value),
    .out_level_class (out_level_class),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #4 clk = ~clk;

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.note_register(cfg_index, cfg_data);
      if (in_valid && !in_stall) sb.note_sample(in_sample);
      if (out_valid && !out_stall) sb.check_level(out_level_value, out_level_class);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WDOG_LIMIT) begin
      $display("audio_level_chain regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side: random stall before each word outside calm blocks, plus the requested long hold-off
  initial begin
    int pause;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        pause = HOLD_CYCLES;
      end else if (calm) begin
        pause = 0;
      end else begin
        pause = $urandom_range(0, MAX_WAIT);
      end
      if (pause > 0) begin
        out_stall <= 1'b1;
        repeat (pause) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  function automatic logic [SAMPLE_W-1:0] draw_sample();
    case ($urandom_range(0, 3))
      0, 1:    return SAMPLE_W'(int'($urandom_range(0, 40)) - 20);
      2:       return SAMPLE_W'(int'($urandom_range(0, 400)) - 200);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic logic [GAIN_W-1:0] draw_gain();
    case ($urandom_range(0, 3))
      0:       return GAIN_W'($urandom);
      1:       return GAIN_W'(int'($urandom_range(0, 2000)) - 1000);
      2:       return GAIN_W'(int'($urandom_range(0, 80)) - 40);
      default: return $urandom_range(0, 1) ? 11'h3FF : 11'h400;
    endcase
  endfunction

  // valid stays high across back-to-back words; dropped only for a gap
  task automatic send_word(input logic [SAMPLE_W-1:0] word);
    int pause;
    pause = calm ? 0 : $urandom_range(0, MAX_WAIT);
    if (pause > 0) begin
      in_valid <= 1'b0;
      repeat (pause) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= word;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.expected_levels.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // upper data bits of the window write are junk the block must mask off
  task automatic program_regs(input logic [WLEN_W-1:0] wl, input logic [GAIN_W-1:0] g,
                              input bit spare);
    logic [CFG_DATA_W-1:0] junk;
    junk = CFG_DATA_W'($urandom);
    cfg_write(CFG_WINDOW_LENGTH, {junk[CFG_DATA_W-1:WLEN_W], wl});
    cfg_write(CFG_GAIN_TENTHS, g);
    if (spare) cfg_write(junk[0] ? CFG_UNMAPPED_A : CFG_UNMAPPED_B, CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [WLEN_W-1:0] wl;
    logic [GAIN_W-1:0] g;
    wait (rst_n);
    @(posedge clk);

    // reset settings: full scale and clip boundaries
    foreach (FULL_SCALE_WORDS[i]) send_word(FULL_SCALE_WORDS[i]);

    // single tap, high gain: overload
    settle();
    program_regs(3'd1, 11'sd1000, 1'b1);
    send_word(16'sd15);
    send_word(-16'sd15);
    send_word(16'sd0);

    // zero window acts as one tap; most negative gain: underload
    settle();
    program_regs(3'd0, 11'h400, 1'b1);
    send_word(-16'sd32768);
    send_word(16'sd1);
    send_word(16'sd7);

    // window above the tap count saturates; gain just over the overload edge
    settle();
    program_regs(3'd7, 11'sd21, 1'b0);
    repeat (3) send_word(16'sd15);
    send_word(-16'sd1);

    for (int b = 0; b < BLOCKS; b++) begin
      settle();
      wl = WLEN_W'($urandom_range(0, 7));
      g  = draw_gain();
      program_regs(wl, g, $urandom_range(0, 2) == 0);
      calm = ($urandom_range(0, 3) == 0);
      if (b == 4 || b == 20) hold_req = 1'b1;
      for (int i = 0; i < BLOCK_WORDS; i++) send_word(draw_sample());
    end

    calm = 1'b0;
    settle();
    if (sb.errors == 0) $display("audio_level_chain regression: pass");
    else $display("audio_level_chain regression: fail");
    $finish;
  end

endmodule
